// ----- rtl/atan2_poly_approx_top_defines.svh -----
// Assertion macros for the atan2 approximation RTL, used by atan2pa_queue.
// Expects clk and rst in the scope of each use.
`ifndef ATAN2_POLY_APPROX_TOP_DEFINES_SVH
`define ATAN2_POLY_APPROX_TOP_DEFINES_SVH

// Property must hold at every clock edge out of reset.
`define A2PA_CHECK(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("atan2pa check failed");

// Condition must never be seen at a clock edge out of reset.
`define A2PA_NEVER(name, expr) \
  `A2PA_CHECK(name, !(expr))

`endif

// ----- rtl/atan2pa_pkg.sv -----
// Shared types and constants for the atan2 approximation block.
// No dependencies.
`timescale 1ns / 1ps
package atan2pa_pkg;

  localparam int IN_W  = 16;
  localparam int ANG_W = 16;
  localparam int NRM_W = 16;

  typedef struct packed {
    logic signed [IN_W-1:0] y_value;
    logic signed [IN_W-1:0] x_value;
  } in_item_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] angle;
    logic                    both_zero;
  } out_item_t;

  // Per-item classification carried from front to back.
  typedef struct packed {
    logic zero;
    logic yneg;
    logic xneg;
    logic swap;
  } ctl_t;

  typedef struct packed {
    ctl_t             ctl;
    logic [NRM_W-1:0] bn;
    logic [NRM_W-1:0] sn;
  } front_item_t;

endpackage

// ----- rtl/atan2pa_queue.sv -----
// Small FIFO used between front and back and as the result buffer.
// Depends on atan2_poly_approx_top_defines.svh for assertion macros.
`timescale 1ns / 1ps
`include "atan2_poly_approx_top_defines.svh"
module atan2pa_queue #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     pop,
  output logic [WIDTH-1:0]         rdata,
  output logic [$clog2(DEPTH):0]   count
);
  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr;
  logic [PW-1:0]    rd;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      if (push) wr <= wr + PW'(1);
      if (pop)  rd <= rd + PW'(1);
      case ({push, pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  assign rdata = mem[rd];

  `A2PA_NEVER(q_no_overflow, push && !pop && count == (PW+1)'(DEPTH))
  `A2PA_NEVER(q_no_underflow, pop && count == '0)
  `A2PA_CHECK(q_count_bound, count <= (PW+1)'(DEPTH))
endmodule

// ----- rtl/atan2pa_front.sv -----
// Front end: takes input items, forms magnitudes, orders and normalizes them.
// Depends on atan2pa_pkg.
`timescale 1ns / 1ps
module atan2pa_front #(
  parameter int QDEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  atan2pa_pkg::in_item_t      sample,
  input  logic [$clog2(QDEPTH):0]    q_count,
  output logic                       q_push,
  output atan2pa_pkg::front_item_t   q_item
);
  import atan2pa_pkg::*;

  localparam int CW = $clog2(QDEPTH) + 1;
  localparam int PW = $clog2(IN_W);

  typedef struct packed {
    ctl_t            ctl;
    logic [IN_W-1:0] big;
    logic [IN_W-1:0] sml;
  } f1_t;

  logic            v1;
  f1_t             r1;
  f1_t             r1_next;
  logic            take;
  logic [CW:0]     occ;
  logic [IN_W-1:0] ay;
  logic [IN_W-1:0] ax;

  // Each item in the two front stages holds a reserved queue slot.
  assign occ  = {1'b0, q_count} + (CW+1)'(v1) + (CW+1)'(q_push);
  assign full = occ >= (CW+1)'(QDEPTH);
  assign take = push && !full;

  always_comb begin
    ay = sample.y_value[IN_W-1] ? IN_W'(-sample.y_value) : IN_W'(sample.y_value);
    ax = sample.x_value[IN_W-1] ? IN_W'(-sample.x_value) : IN_W'(sample.x_value);
    r1_next.ctl.yneg = sample.y_value[IN_W-1];
    r1_next.ctl.xneg = sample.x_value[IN_W-1];
    r1_next.ctl.zero = (ay == '0) && (ax == '0);
    r1_next.ctl.swap = ax < ay;
    r1_next.big      = (ax < ay) ? ay : ax;
    r1_next.sml      = (ax < ay) ? ax : ay;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= take;
    end
  end

  always_ff @(posedge clk) begin
    r1 <= r1_next;
  end

  // Bring the larger magnitude into [2^15, 2^16); truncate the smaller alike.
  logic [PW-1:0]         lead;
  logic [IN_W+NRM_W-1:0] wb;
  logic [IN_W+NRM_W-1:0] ws;
  front_item_t           f2_next;

  always_comb begin
    lead = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (r1.big[i]) lead = PW'(i);
    end
    wb = {r1.big, NRM_W'(0)} >> (int'(lead) + 1);
    ws = {r1.sml, NRM_W'(0)} >> (int'(lead) + 1);
    f2_next.ctl = r1.ctl;
    f2_next.bn  = wb[NRM_W-1:0];
    f2_next.sn  = ws[NRM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_push <= 1'b0;
    end else begin
      q_push <= v1;
    end
  end

  always_ff @(posedge clk) begin
    q_item <= f2_next;
  end
endmodule

// ----- rtl/atan2pa_back.sv -----
// Back end: root, divide, arcsine polynomial and quadrant reflection pipeline.
// Depends on atan2pa_pkg.
`timescale 1ns / 1ps
module atan2pa_back #(
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                       clk,
  input  logic                       rst,
  input  atan2pa_pkg::front_item_t   head,
  input  logic                       head_valid,
  output logic                       head_pop,
  input  logic                       res_full,
  output logic                       res_push,
  output atan2pa_pkg::out_item_t     res
);
  import atan2pa_pkg::*;

  localparam int NST = 107;
  localparam int SH  = 30 - ANGLE_FRAC_BITS;
  localparam logic [34:0] RND_ADD = 35'(1) << (29 - ANGLE_FRAC_BITS);

  localparam logic [34:0] HALF_PI = 35'd1686629713;
  localparam logic [34:0] PI_Q30  = 35'd3373259426;
  localparam logic [29:0] C_ASIN3 = 30'd178957006;
  localparam logic [29:0] C_ASIN5 = 30'd80530640;
  localparam logic [29:0] C_ASIN7 = 30'd57961916;
  localparam logic [29:0] C_HALF3 = 30'd357913916;
  localparam logic [29:0] C_HALF5 = 30'd161061284;
  localparam logic [29:0] C_HALF7 = 30'd115923852;

  typedef struct packed {
    ctl_t        ctl;
    logic [15:0] bn;
    logic [15:0] sn;
    logic [31:0] sq_b;
    logic [31:0] sq_s;
    logic [63:0] rem;
    logic [31:0] root;
    logic [31:0] r;
    logic [30:0] quo;
    logic [29:0] s;
    logic        hb;
    logic [29:0] u;
    logic [29:0] u2;
    logic [29:0] u3;
    logic [29:0] u5;
    logic [29:0] u7;
    logic [29:0] p3;
    logic [29:0] p5;
    logic [29:0] p7;
    logic [31:0] a;
    out_item_t   out;
  } bk_t;

  function automatic logic [29:0] q30_mul(logic [29:0] x, logic [29:0] y);
    logic [59:0] m;
    logic [60:0] p;
    m = x * y;
    p = {1'b0, m} + (61'd1 << 29);
    return p[59:30];
  endfunction

  logic adv;
  bk_t  head_st;
  bk_t  in_st [NST];
  bk_t  nxt   [NST];
  bk_t  pipe  [1:NST];
  logic vin   [NST];
  logic vld   [1:NST];

  // Whole pipe holds while the result buffer is full.
  assign adv      = !res_full;
  assign head_pop = adv && head_valid;
  assign res_push = adv && vld[NST];
  assign res      = pipe[NST].out;

  always_comb begin
    head_st     = '0;
    head_st.ctl = head.ctl;
    head_st.bn  = head.bn;
    head_st.sn  = head.sn;
  end

  for (genvar k = 0; k < NST; k++) begin : g_stage
    if (k == 0) begin : g_in
      assign in_st[k] = head_st;
      assign vin[k]   = head_valid;
    end else begin : g_mid
      assign in_st[k] = pipe[k];
      assign vin[k]   = vld[k];
    end

    if (k == 0) begin : g_sq
      always_comb begin
        nxt[k]      = in_st[k];
        nxt[k].sq_b = in_st[k].bn * in_st[k].bn;
        nxt[k].sq_s = in_st[k].sn * in_st[k].sn;
      end
    end else if (k == 1) begin : g_sum
      always_comb begin
        nxt[k]      = in_st[k];
        nxt[k].rem  = {31'b0, {1'b0, in_st[k].sq_b} + {1'b0, in_st[k].sq_s}} << 30;
        nxt[k].root = '0;
      end
    end else if (k <= 33 || (k >= 67 && k <= 98)) begin : g_root
      localparam int B = (k <= 33) ? (33 - k) : (98 - k);
      always_comb begin : stp
        logic [63:0] trial;
        trial  = ({31'b0, in_st[k].root, 1'b0} | (64'd1 << B)) << B;
        nxt[k] = in_st[k];
        if (trial <= in_st[k].rem) begin
          nxt[k].rem  = in_st[k].rem - trial;
          nxt[k].root = in_st[k].root | (32'd1 << B);
        end
      end
    end else if (k == 34) begin : g_dinit
      always_comb begin
        nxt[k]     = in_st[k];
        nxt[k].r   = in_st[k].root;
        nxt[k].rem = {3'b0, in_st[k].sn, 45'b0};
        nxt[k].quo = '0;
      end
    end else if (k <= 65) begin : g_div
      localparam int B = 65 - k;
      always_comb begin : stp
        logic [63:0] dv;
        dv     = {32'b0, in_st[k].r} << B;
        nxt[k] = in_st[k];
        if (dv <= in_st[k].rem) begin
          nxt[k].rem = in_st[k].rem - dv;
          nxt[k].quo = in_st[k].quo | (31'd1 << B);
        end
      end
    end else if (k == 66) begin : g_half
      always_comb begin : stp
        logic [29:0] sc;
        logic [30:0] t;
        sc          = in_st[k].quo[30] ? 30'h3FFF_FFFF : in_st[k].quo[29:0];
        t           = (31'h4000_0000 - {1'b0, sc}) >> 1;
        nxt[k]      = in_st[k];
        nxt[k].s    = sc;
        nxt[k].hb   = sc[29];
        nxt[k].rem  = {4'b0, t[29:0], 30'b0};
        nxt[k].root = '0;
      end
    end else if (k == 99) begin : g_sel
      always_comb begin
        nxt[k]   = in_st[k];
        nxt[k].u = in_st[k].hb ? in_st[k].root[29:0] : in_st[k].s;
      end
    end else if (k == 100) begin : g_u2
      always_comb begin
        nxt[k]    = in_st[k];
        nxt[k].u2 = q30_mul(in_st[k].u, in_st[k].u);
      end
    end else if (k == 101) begin : g_u3
      always_comb begin
        nxt[k]    = in_st[k];
        nxt[k].u3 = q30_mul(in_st[k].u2, in_st[k].u);
      end
    end else if (k == 102) begin : g_u5
      always_comb begin
        nxt[k]    = in_st[k];
        nxt[k].u5 = q30_mul(in_st[k].u3, in_st[k].u2);
      end
    end else if (k == 103) begin : g_u7
      always_comb begin
        nxt[k]    = in_st[k];
        nxt[k].u7 = q30_mul(in_st[k].u5, in_st[k].u2);
      end
    end else if (k == 104) begin : g_coef
      always_comb begin
        nxt[k]    = in_st[k];
        nxt[k].p3 = q30_mul(in_st[k].u3, in_st[k].hb ? C_HALF3 : C_ASIN3);
        nxt[k].p5 = q30_mul(in_st[k].u5, in_st[k].hb ? C_HALF5 : C_ASIN5);
        nxt[k].p7 = q30_mul(in_st[k].u7, in_st[k].hb ? C_HALF7 : C_ASIN7);
      end
    end else if (k == 105) begin : g_asin
      always_comb begin : stp
        logic [34:0] d;
        logic [34:0] sm;
        d  = HALF_PI - {5'b0, in_st[k].p7} - {5'b0, in_st[k].p5} - {5'b0, in_st[k].p3}
             - {4'b0, in_st[k].u, 1'b0};
        sm = {5'b0, in_st[k].u} + {5'b0, in_st[k].p3} + {5'b0, in_st[k].p5}
             + {5'b0, in_st[k].p7};
        nxt[k] = in_st[k];
        if (in_st[k].hb) begin
          nxt[k].a = d[34] ? 32'd0 : d[31:0];
        end else begin
          nxt[k].a = sm[31:0];
        end
      end
    end else begin : g_out
      always_comb begin : stp
        logic [34:0] a0;
        logic [34:0] a1;
        logic [34:0] mag;
        a0  = in_st[k].ctl.swap ? (HALF_PI - {3'b0, in_st[k].a}) : {3'b0, in_st[k].a};
        a1  = in_st[k].ctl.xneg ? (PI_Q30 - a0) : a0;
        if (a1[34]) a1 = '0;
        mag = (a1 + RND_ADD) >> SH;
        nxt[k] = in_st[k];
        if (in_st[k].ctl.zero) begin
          nxt[k].out.angle     = '0;
          nxt[k].out.both_zero = 1'b1;
        end else begin
          nxt[k].out.angle     = in_st[k].ctl.yneg ? -mag[ANG_W-1:0] : mag[ANG_W-1:0];
          nxt[k].out.both_zero = 1'b0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vin[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pipe[k+1] <= nxt[k];
      end
    end
  end
endmodule

// ----- rtl/atan2_poly_approx_top.sv -----
// Top level of the atan2 approximation: front, queue, back and result buffer.
// Depends on atan2pa_pkg, atan2pa_front, atan2pa_queue, atan2pa_back.
//
//   channel   handshake        payload
//   input     push / full      sample : in_item_t  (y_value, x_value)
//   result    pop / empty      result : out_item_t (angle, both_zero)
//
// One item enters per cycle while full is low, and one result leaves per cycle
// while pop is held and empty is low. A result reaches the ports through two
// front stages, one write into the front queue, 107 back stages (two 32-step
// root units and a 31-step divider set the depth), and one write into the
// result buffer. Reset clears all valid bits and queue pointers.
// When the result buffer fills, the back pipe holds; the front keeps taking
// items until its queue slots are used up, then raises full.
`timescale 1ns / 1ps
module atan2_poly_approx_top #(
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  atan2pa_pkg::in_item_t   sample,
  output logic                    empty,
  input  logic                    pop,
  output atan2pa_pkg::out_item_t  result
);
  import atan2pa_pkg::*;

  localparam int MID_DEPTH = 8;
  localparam int RES_DEPTH = 4;

  logic                       mq_push;
  front_item_t                mq_wdata;
  logic [$bits(front_item_t)-1:0] mq_rdata;
  logic [$clog2(MID_DEPTH):0] mq_count;
  logic                       mq_pop;

  logic                       rq_push;
  out_item_t                  rq_wdata;
  logic [$bits(out_item_t)-1:0] rq_rdata;
  logic [$clog2(RES_DEPTH):0] rq_count;

  atan2pa_front #(.QDEPTH(MID_DEPTH)) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .sample  (sample),
    .q_count (mq_count),
    .q_push  (mq_push),
    .q_item  (mq_wdata)
  );

  atan2pa_queue #(.DEPTH(MID_DEPTH), .WIDTH($bits(front_item_t))) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mq_push),
    .wdata (mq_wdata),
    .pop   (mq_pop),
    .rdata (mq_rdata),
    .count (mq_count)
  );

  atan2pa_back #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (front_item_t'(mq_rdata)),
    .head_valid (mq_count != '0),
    .head_pop   (mq_pop),
    .res_full   (rq_count == ($clog2(RES_DEPTH)+1)'(RES_DEPTH)),
    .res_push   (rq_push),
    .res        (rq_wdata)
  );

  atan2pa_queue #(.DEPTH(RES_DEPTH), .WIDTH($bits(out_item_t))) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rq_push),
    .wdata (rq_wdata),
    .pop   (pop && !empty),
    .rdata (rq_rdata),
    .count (rq_count)
  );

  assign empty  = rq_count == '0;
  assign result = out_item_t'(rq_rdata);
endmodule

// ----- sim/atan2_poly_approx_top_tb.sv -----
// Testbench for atan2_poly_approx_top: directed table then random vector pairs.
// Depends on atan2pa_pkg and the block RTL; predicts non-fixed angles bit-exactly.
`timescale 1ns / 1ps
module atan2_poly_approx_top_tb;
  import atan2pa_pkg::*;

  localparam int FRAC = 13;
  localparam int N_RANDOM = 1830;
  localparam longint unsigned Q_ONE = 64'd1073741824;
  localparam longint unsigned Q_HALF = 64'd536870912;
  localparam longint Q_HALF_PI = 64'sd1686629713;
  localparam longint Q_PI = 64'sd3373259426;
  localparam longint unsigned K_A3 = 64'd178957006;
  localparam longint unsigned K_A5 = 64'd80530640;
  localparam longint unsigned K_A7 = 64'd57961916;
  localparam longint unsigned K_H3 = 64'd357913916;
  localparam longint unsigned K_H5 = 64'd161061284;
  localparam longint unsigned K_H7 = 64'd115923852;

  typedef enum int { CHK_PRED, CHK_FIXED } chk_mode_e;

  typedef struct {
    logic signed [15:0] y;
    logic signed [15:0] x;
    chk_mode_e          mode;
    logic signed [15:0] ang;
    logic               zero;
  } vec_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  logic      full;
  logic      empty;
  in_item_t  sample = '0;
  out_item_t drv_exp = '0;
  out_item_t result;

  out_item_t angle_q[$];
  int        mismatches = 0;
  int        send_idle = 28;
  int        recv_idle = 82;
  vec_row_t  vec_tab[$];

  atan2_poly_approx_top u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .sample(sample), .empty(empty), .pop(pop), .result(result)
  );

  always #1 clk = ~clk;

  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned arcsine_q30(longint unsigned s);
    longint unsigned v, v2, v3, v5, v7;
    longint r;
    if (s >= Q_HALF) begin
      v = int_sqrt(((Q_ONE - s) >> 1) << 30);
      v2 = qmul(v, v);
      v3 = qmul(v2, v);
      v5 = qmul(v3, v2);
      v7 = qmul(v5, v2);
      r = Q_HALF_PI - longint'(qmul(v7, K_H7)) - longint'(qmul(v5, K_H5))
          - longint'(qmul(v3, K_H3)) - longint'(v + v);
      return r < 0 ? 0 : longint'(r);
    end
    v2 = qmul(s, s);
    v3 = qmul(v2, s);
    v5 = qmul(v3, v2);
    v7 = qmul(v5, v2);
    return s + qmul(v3, K_A3) + qmul(v5, K_A5) + qmul(v7, K_A7);
  endfunction

  function automatic out_item_t predict_angle(logic signed [15:0] y, logic signed [15:0] x);
    out_item_t o;
    longint unsigned ay, ax, big, sml, r, s, mag;
    longint ang;
    ay = y[15] ? 64'd65536 - {48'd0, y} : {48'd0, y};
    ax = x[15] ? 64'd65536 - {48'd0, x} : {48'd0, x};
    o = '0;
    if (ay == 0 && ax == 0) begin
      o.both_zero = 1'b1;
      return o;
    end
    big = ax >= ay ? ax : ay;
    sml = ax >= ay ? ay : ax;
    while (big >= 64'd65536) begin
      big >>= 1;
      sml >>= 1;
    end
    while (big < 64'd32768) begin
      big <<= 1;
      sml <<= 1;
    end
    r = int_sqrt((big * big + sml * sml) << 30);
    s = (sml << 45) / r;
    if (s >= Q_ONE) s = Q_ONE - 1;
    ang = ax >= ay ? longint'(arcsine_q30(s)) : Q_HALF_PI - longint'(arcsine_q30(s));
    if (x[15]) ang = Q_PI - ang;
    if (ang < 0) ang = 0;
    mag = (longint'(ang) + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
    if (y[15]) mag = 64'd0 - mag;
    o.angle = mag[15:0];
    return o;
  endfunction

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 15)) - 16'd8;
      1: return 16'h8000 + 16'($urandom_range(0, 3));
      2: return 16'h7fff - 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  // hold push high from one item to the next; drop it only while idling
  task automatic send_pair(logic [15:0] y, logic [15:0] x, out_item_t exp_o);
    while ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    sample <= '{y_value: y, x_value: x};
    drv_exp <= exp_o;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // queue expectations at the accepting edge
  always @(posedge clk) begin
    if (!rst && push && !full) angle_q.push_back(drv_exp);
  end

  always @(posedge clk) begin
    out_item_t exp_o;
    if (!rst && pop && !empty) begin
      if (angle_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result angle=%0d", result.angle);
      end else begin
        exp_o = angle_q.pop_front();
        if (result.angle !== exp_o.angle || result.both_zero !== exp_o.both_zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: angle exp %0d got %0d, both_zero exp %0b got %0b",
                     exp_o.angle, result.angle, exp_o.both_zero, result.both_zero);
        end
      end
    end
    pop <= ($urandom_range(0, 99) >= recv_idle);
  end

  initial begin
    #2000000;
    $display("atan2_poly_approx_top regression: fail");
    $finish;
  end

  initial begin
    logic [15:0] ry;
    logic [15:0] rx;
    out_item_t   fx;
    vec_tab = '{
      '{16'sd0, 16'sd0, CHK_FIXED, 16'sd0, 1'b1},
      '{16'sd0, 16'sd100, CHK_FIXED, 16'sd0, 1'b0},
      '{16'sd0, 16'sd1, CHK_FIXED, 16'sd0, 1'b0},
      '{16'sd1, 16'sd0, CHK_PRED, 16'sd0, 1'b0},
      '{-16'sd1, 16'sd0, CHK_PRED, 16'sd0, 1'b0},
      '{16'sd0, -16'sd1, CHK_PRED, 16'sd0, 1'b0},
      '{16'sd5, 16'sd5, CHK_PRED, 16'sd0, 1'b0},
      '{-16'sd5, -16'sd5, CHK_PRED, 16'sd0, 1'b0},
      '{16'sh7fff, 16'sh7fff, CHK_PRED, 16'sd0, 1'b0},
      '{-16'sd32768, -16'sd32768, CHK_PRED, 16'sd0, 1'b0},
      '{-16'sd32768, 16'sd0, CHK_PRED, 16'sd0, 1'b0},
      '{16'sd0, -16'sd32768, CHK_PRED, 16'sd0, 1'b0},
      '{16'sh7fff, -16'sd32768, CHK_PRED, 16'sd0, 1'b0},
      '{-16'sd32768, 16'sh7fff, CHK_PRED, 16'sd0, 1'b0},
      '{16'sd1, 16'sd2, CHK_PRED, 16'sd0, 1'b0},
      '{16'sd1, 16'sd1000, CHK_PRED, 16'sd0, 1'b0},
      '{16'sd3000, -16'sd7, CHK_PRED, 16'sd0, 1'b0},
      '{-16'sd1234, 16'sd2000, CHK_PRED, 16'sd0, 1'b0},
      '{16'sd1, -16'sd2, CHK_PRED, 16'sd0, 1'b0},
      '{-16'sd1, -16'sd20000, CHK_PRED, 16'sd0, 1'b0}
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (vec_tab.size() != 0) begin
      if (vec_tab[0].mode == CHK_FIXED) begin
        fx.angle     = vec_tab[0].ang;
        fx.both_zero = vec_tab[0].zero;
      end else begin
        fx = predict_angle(vec_tab[0].y, vec_tab[0].x);
      end
      send_pair(vec_tab[0].y, vec_tab[0].x, fx);
      void'(vec_tab.pop_front());
    end
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 28 : (ph == 1) ? 82 : 0;
      recv_idle = (ph == 0) ? 82 : (ph == 1) ? 28 : 0;
      for (int i = 0; i < N_RANDOM / 3; i++) begin
        ry = rand_field();
        rx = rand_field();
        send_pair(ry, rx, predict_angle(ry, rx));
      end
      // drain before the next phase
      push <= 1'b0;
      @(posedge clk);
      while (angle_q.size() != 0) @(posedge clk);
    end
    repeat (150) @(posedge clk);
    if (mismatches == 0 && angle_q.size() == 0) begin
      $display("atan2_poly_approx_top regression: pass");
    end else begin
      $display("atan2_poly_approx_top regression: fail");
    end
    $finish;
  end
endmodule
